// ----- rtl/sia_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sia_pkg
// Shared types and constants for the shuffled image add-and-clip block.
// ----------------------------------------------------------------------------
package sia_pkg;

   localparam int KIND_W     = 2;
   localparam int FIRST_W    = 8;
   localparam int SECOND_W   = 16;
   localparam int RAND_W     = 31;
   localparam int CNT_W      = 17;
   localparam int STORE_AW   = 16;
   localparam int STORE_DEPTH = 65536;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 9;

   localparam logic [KIND_W-1:0] KIND_LOAD    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SHUFFLE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_PIXEL   = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COL_COUNT = 1'd1;

   localparam logic [FIRST_W-1:0] PIXEL_MAX = 8'd255;
   localparam logic [CNT_W-1:0]   CNT_MAX   = '1;

   typedef struct packed {
      logic [KIND_W-1:0]          kind;
      logic [FIRST_W-1:0]         first_pixel;
      logic signed [SECOND_W-1:0] second_pixel;
      logic [RAND_W-1:0]          random_word;
   } sia_req_type;

   typedef struct packed {
      logic [FIRST_W-1:0] out_pixel;
      logic               clipped_low;
      logic               clipped_high;
      logic [CNT_W-1:0]   low_clip_total;
      logic [CNT_W-1:0]   high_clip_total;
      logic               frame_end;
   } sia_rsp_type;

   typedef struct packed {
      logic              start;
      logic [RAND_W-1:0] dividend;
   } sia_div_req_type;

endpackage
`default_nettype wire

// ----- rtl/sia_rem_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sia_rem_unit
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
module sia_rem_unit #(
   parameter int DIVISOR_W = 9
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire sia_pkg::sia_div_req_type     div_req,
   input  wire logic [DIVISOR_W-1:0]         divisor,
   output logic                              done,
   output logic [DIVISOR_W-1:0]              remainder
);

   localparam int STEP_W = $clog2(sia_pkg::RAND_W);

   logic                       busy_ff;
   logic                       done_ff;
   logic [STEP_W-1:0]          step_ff;
   logic [sia_pkg::RAND_W-1:0] num_ff;
   logic [DIVISOR_W-1:0]       rem_ff;
   logic [DIVISOR_W-1:0]       den_ff;
   logic [DIVISOR_W:0]         trial;
   logic [DIVISOR_W-1:0]       rem_in;

   // The partial remainder stays below the divisor, so the trial value is
   // below twice the divisor and one subtraction restores it.
   always_comb begin
      trial = {rem_ff, num_ff[sia_pkg::RAND_W-1]};
      if (trial >= {1'b0, den_ff}) begin
         rem_in = DIVISOR_W'(trial - {1'b0, den_ff});
      end else begin
         rem_in = DIVISOR_W'(trial);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && step_ff == '0) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         num_ff  <= div_req.dividend;
         rem_ff  <= '0;
         den_ff  <= divisor;
         step_ff <= STEP_W'(sia_pkg::RAND_W - 1);
      end else if (busy_ff) begin
         num_ff  <= {num_ff[sia_pkg::RAND_W-2:0], 1'b0};
         rem_ff  <= rem_in;
         step_ff <= step_ff - 1'b1;
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule
`default_nettype wire

// ----- rtl/shuffled_image_add_clip.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// shuffled_image_add_clip
// Adds byte pixels to a row- and column-shuffled signed image and clips.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake            | Payload
//  req_    | in        | req_valid, req_stall | sia_req_type
//  rsp_    | out       | rsp_valid, rsp_stall | sia_rsp_type
//  csr_    | in        | csr_valid, csr_ready | csr_index, csr_wdata
//
//  Load and pixel items enter one per cycle while the input is not stalled; a
// pixel's result then passes the permutation read, the address multiply, the
// image store read and the output register.
// A shuffle item holds the input while the 31-step serial remainder unit runs
// and the swap does its read and two writes.
// After reset both permutation tables, and after each size write the table of
// that size, are rewritten to identity, one entry a cycle, while the input is
// stalled. A stalled output freezes the whole pipeline.
// ----------------------------------------------------------------------------
module shuffled_image_add_clip #(
   parameter int MAX_ROWS = 256,
   parameter int MAX_COLS = 256
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire sia_pkg::sia_req_type             req_data,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output sia_pkg::sia_rsp_type                  rsp_data,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [sia_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [sia_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int RIW   = $clog2(MAX_ROWS);
   localparam int CIW   = $clog2(MAX_COLS);
   localparam int RCW   = $clog2(MAX_ROWS + 1);
   localparam int CCW   = $clog2(MAX_COLS + 1);
   localparam int LEN_W = (RCW > CCW) ? RCW : CCW;
   localparam int FRW   = $clog2(MAX_ROWS * MAX_COLS + 1);

   typedef enum logic [4:0] {
      SH_IDLE   = 5'b00001,
      SH_DIV    = 5'b00010,
      SH_READ   = 5'b00100,
      SH_SWAP_K = 5'b01000,
      SH_SWAP_I = 5'b10000
   } sh_state_type;

   function automatic logic [RCW-1:0] clamp_rows(input logic [sia_pkg::CSR_DATA_W-1:0] v);
      if (v == '0) begin
         return RCW'(1);
      end else if (int'(v) > MAX_ROWS) begin
         return RCW'(MAX_ROWS);
      end else begin
         return RCW'(v);
      end
   endfunction

   function automatic logic [CCW-1:0] clamp_cols(input logic [sia_pkg::CSR_DATA_W-1:0] v);
      if (v == '0) begin
         return CCW'(1);
      end else if (int'(v) > MAX_COLS) begin
         return CCW'(MAX_COLS);
      end else begin
         return CCW'(v);
      end
   endfunction

   // Configuration and stream position state.
   logic [RCW-1:0]   row_count_ff;
   logic [CCW-1:0]   col_count_ff;
   logic [FRW-1:0]   frame_ff;
   logic [FRW-1:0]   load_pos_ff;
   logic [FRW-1:0]   load_pos_in;
   logic [LEN_W:0]   swap_step_ff;
   logic [LEN_W:0]   swap_step_in;
   logic [RIW-1:0]   pixel_row_ff;
   logic [RIW-1:0]   pixel_row_in;
   logic [CIW-1:0]   pixel_col_ff;
   logic [CIW-1:0]   pixel_col_in;
   logic [sia_pkg::CNT_W-1:0] low_clips_ff;
   logic [sia_pkg::CNT_W-1:0] high_clips_ff;

   logic             row_sweep_busy_ff;
   logic [RIW-1:0]   row_sweep_idx_ff;
   logic             col_sweep_busy_ff;
   logic [CIW-1:0]   col_sweep_idx_ff;

   // Shuffle sequencer.
   sh_state_type     sh_state_ff;
   logic             sh_col_ff;
   logic [LEN_W-1:0] sh_i_ff;
   logic [LEN_W-1:0] sh_k_ff;

   // Permutation and image memories.
   logic [RIW-1:0]   row_mem [MAX_ROWS];
   logic [CIW-1:0]   col_mem [MAX_COLS];
   logic [sia_pkg::SECOND_W-1:0] store_mem [sia_pkg::STORE_DEPTH];
   logic [RIW-1:0]   row_rd_a_ff;
   logic [RIW-1:0]   row_rd_b_ff;
   logic [CIW-1:0]   col_rd_a_ff;
   logic [CIW-1:0]   col_rd_b_ff;
   logic [sia_pkg::SECOND_W-1:0] store_rd_ff;

   // Pipeline stages.
   logic             p1_valid_ff, p1_pixel_ff, p1_start_ff, p1_last_ff;
   logic [sia_pkg::FIRST_W-1:0]  p1_first_ff;
   logic [sia_pkg::SECOND_W-1:0] p1_second_ff;
   logic [sia_pkg::STORE_AW-1:0] p1_addr_ff;
   logic             p2_valid_ff, p2_pixel_ff, p2_start_ff, p2_last_ff;
   logic [sia_pkg::FIRST_W-1:0]  p2_first_ff;
   logic [sia_pkg::SECOND_W-1:0] p2_second_ff;
   logic [sia_pkg::STORE_AW-1:0] p2_addr_ff;
   logic [FRW-1:0]   p2_prod_ff;
   logic [CIW-1:0]   p2_cp_ff;
   logic             p3_valid_ff, p3_pixel_ff, p3_start_ff, p3_last_ff;
   logic [sia_pkg::FIRST_W-1:0]  p3_first_ff;
   logic             rsp_valid_ff;
   sia_pkg::sia_rsp_type rsp_ff;
   sia_pkg::sia_rsp_type rsp_in;

   logic             adv;
   logic             accept;
   logic             csr_we;
   logic             load_acc;
   logic             pix_acc;
   logic             sh_acc;
   logic             sh_start;
   logic             sh_read_go;
   logic [RIW-1:0]   cur_row;
   logic [CIW-1:0]   cur_col;
   logic             cur_start;
   logic             cur_last;
   logic [RCW-1:0]   row_steps;
   logic [CCW-1:0]   col_steps;
   logic [LEN_W:0]   total;
   logic [LEN_W:0]   step;
   logic [LEN_W:0]   step_inc;
   logic             step_in_rows;
   logic [LEN_W-1:0] sh_i_in;
   logic [LEN_W-1:0] sh_len;
   logic [LEN_W-1:0] sh_divisor;
   logic             div_done;
   logic [LEN_W-1:0] div_rem;
   sia_pkg::sia_div_req_type div_req;
   logic [sia_pkg::STORE_AW-1:0] store_addr;
   logic [sia_pkg::CNT_W:0] sum;
   logic             sum_low;
   logic             sum_high;
   logic [sia_pkg::CNT_W-1:0] low_base;
   logic [sia_pkg::CNT_W-1:0] high_base;

   logic             row_we;
   logic [RIW-1:0]   row_waddr;
   logic [RIW-1:0]   row_wdata;
   logic [RIW-1:0]   row_raddr_a;
   logic             col_we;
   logic [CIW-1:0]   col_waddr;
   logic [CIW-1:0]   col_wdata;
   logic [CIW-1:0]   col_raddr_a;
   logic             perm_re;

   // ------------------------------------------------------------------------
   // Handshakes
   // ------------------------------------------------------------------------
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv || row_sweep_busy_ff || col_sweep_busy_ff ||
                      (sh_state_ff != SH_IDLE);
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;

   assign load_acc  = accept && (req_data.kind == sia_pkg::KIND_LOAD);
   assign sh_acc    = accept && (req_data.kind == sia_pkg::KIND_SHUFFLE);
   assign pix_acc   = accept && (req_data.kind == sia_pkg::KIND_PIXEL);

   // ------------------------------------------------------------------------
   // Stream positions
   // ------------------------------------------------------------------------
   always_comb begin
      if (RCW'(pixel_row_ff) >= row_count_ff || CCW'(pixel_col_ff) >= col_count_ff) begin
         cur_row = '0;
         cur_col = '0;
      end else begin
         cur_row = pixel_row_ff;
         cur_col = pixel_col_ff;
      end
      cur_start = (cur_row == '0) && (cur_col == '0);
      cur_last  = (RCW'(cur_row) == row_count_ff - 1'b1) &&
                  (CCW'(cur_col) == col_count_ff - 1'b1);

      if (CCW'(cur_col) + 1'b1 >= col_count_ff) begin
         pixel_col_in = '0;
         if (RCW'(cur_row) + 1'b1 >= row_count_ff) begin
            pixel_row_in = '0;
         end else begin
            pixel_row_in = cur_row + 1'b1;
         end
      end else begin
         pixel_col_in = cur_col + 1'b1;
         pixel_row_in = cur_row;
      end

      if (load_pos_ff + 1'b1 >= frame_ff) begin
         load_pos_in = '0;
      end else begin
         load_pos_in = load_pos_ff + 1'b1;
      end
   end

   // Fisher-Yates step selection: row steps first, then column steps.
   always_comb begin
      row_steps    = row_count_ff - 1'b1;
      col_steps    = col_count_ff - 1'b1;
      total        = (LEN_W + 1)'(row_steps) + (LEN_W + 1)'(col_steps);
      step         = (swap_step_ff >= total) ? '0 : swap_step_ff;
      step_in_rows = step < (LEN_W + 1)'(row_steps);
      if (step_in_rows) begin
         sh_i_in = LEN_W'(step);
         sh_len  = LEN_W'(row_count_ff);
      end else begin
         sh_i_in = LEN_W'(step - (LEN_W + 1)'(row_steps));
         sh_len  = LEN_W'(col_count_ff);
      end
      sh_divisor = sh_len - sh_i_in;
      step_inc   = step + 1'b1;
      swap_step_in = (step_inc >= total) ? '0 : step_inc;
      sh_start   = sh_acc && (total != '0);
   end

   assign div_req.start    = sh_start;
   assign div_req.dividend = req_data.random_word;

   sia_rem_unit #(
      .DIVISOR_W (LEN_W)
   ) u_rem (
      .clock     (clock),
      .reset     (reset),
      .div_req   (div_req),
      .divisor   (sh_divisor),
      .done      (div_done),
      .remainder (div_rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff      <= RCW'(MAX_ROWS);
         col_count_ff      <= CCW'(MAX_COLS);
         load_pos_ff       <= '0;
         swap_step_ff      <= '0;
         pixel_row_ff      <= '0;
         pixel_col_ff      <= '0;
         row_sweep_busy_ff <= 1'b1;
         row_sweep_idx_ff  <= '0;
         col_sweep_busy_ff <= 1'b1;
         col_sweep_idx_ff  <= '0;
      end else begin
         if (row_sweep_busy_ff) begin
            row_sweep_idx_ff <= row_sweep_idx_ff + 1'b1;
            if (row_sweep_idx_ff == RIW'(MAX_ROWS - 1)) begin
               row_sweep_busy_ff <= 1'b0;
            end
         end
         if (col_sweep_busy_ff) begin
            col_sweep_idx_ff <= col_sweep_idx_ff + 1'b1;
            if (col_sweep_idx_ff == CIW'(MAX_COLS - 1)) begin
               col_sweep_busy_ff <= 1'b0;
            end
         end

         if (load_acc) begin
            load_pos_ff <= load_pos_in;
         end
         if (sh_start) begin
            swap_step_ff <= swap_step_in;
         end
         if (pix_acc) begin
            pixel_row_ff <= pixel_row_in;
            pixel_col_ff <= pixel_col_in;
         end

         // A size write restarts every stream, whether or not the size changed.
         if (csr_we) begin
            case (csr_index)
               sia_pkg::CSR_ROW_COUNT: begin
                  row_count_ff      <= clamp_rows(csr_wdata);
                  row_sweep_busy_ff <= 1'b1;
                  row_sweep_idx_ff  <= '0;
               end
               sia_pkg::CSR_COL_COUNT: begin
                  col_count_ff      <= clamp_cols(csr_wdata);
                  col_sweep_busy_ff <= 1'b1;
                  col_sweep_idx_ff  <= '0;
               end
               default: begin
               end
            endcase
            load_pos_ff  <= '0;
            swap_step_ff <= '0;
            pixel_row_ff <= '0;
            pixel_col_ff <= '0;
         end
      end
   end

   // Frame size follows the counts; the sweep after a size write covers the lag.
   always_ff @(posedge clock) begin
      frame_ff <= FRW'(FRW'(row_count_ff) * FRW'(col_count_ff));
   end

   // ------------------------------------------------------------------------
   // Shuffle sequencer
   // ------------------------------------------------------------------------
   assign sh_read_go = (sh_state_ff == SH_READ) && !p1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sh_state_ff <= SH_IDLE;
      end else begin
         case (sh_state_ff)
            SH_IDLE: begin
               if (sh_start) begin
                  sh_state_ff <= SH_DIV;
               end
            end
            SH_DIV: begin
               if (div_done) begin
                  sh_state_ff <= SH_READ;
               end
            end
            SH_READ: begin
               // The permutation read data registers still belong to a pixel
               // in the first stage until that pixel moves on.
               if (!p1_valid_ff) begin
                  sh_state_ff <= SH_SWAP_K;
               end
            end
            SH_SWAP_K: begin
               sh_state_ff <= SH_SWAP_I;
            end
            SH_SWAP_I: begin
               sh_state_ff <= SH_IDLE;
            end
            default: begin
               sh_state_ff <= SH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (sh_start) begin
         sh_i_ff   <= sh_i_in;
         sh_col_ff <= !step_in_rows;
      end
      if (sh_state_ff == SH_DIV && div_done) begin
         sh_k_ff <= div_rem + sh_i_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Permutation tables
   // ------------------------------------------------------------------------
   assign perm_re = pix_acc || sh_read_go;

   always_comb begin
      row_we      = row_sweep_busy_ff ||
                    (!sh_col_ff && (sh_state_ff == SH_SWAP_K || sh_state_ff == SH_SWAP_I));
      row_raddr_a = sh_read_go ? RIW'(sh_i_ff) : cur_row;
      if (row_sweep_busy_ff) begin
         row_waddr = row_sweep_idx_ff;
         row_wdata = row_sweep_idx_ff;
      end else if (sh_state_ff == SH_SWAP_K) begin
         row_waddr = RIW'(sh_k_ff);
         row_wdata = row_rd_a_ff;
      end else begin
         row_waddr = RIW'(sh_i_ff);
         row_wdata = row_rd_b_ff;
      end

      col_we      = col_sweep_busy_ff ||
                    (sh_col_ff && (sh_state_ff == SH_SWAP_K || sh_state_ff == SH_SWAP_I));
      col_raddr_a = sh_read_go ? CIW'(sh_i_ff) : cur_col;
      if (col_sweep_busy_ff) begin
         col_waddr = col_sweep_idx_ff;
         col_wdata = col_sweep_idx_ff;
      end else if (sh_state_ff == SH_SWAP_K) begin
         col_waddr = CIW'(sh_k_ff);
         col_wdata = col_rd_a_ff;
      end else begin
         col_waddr = CIW'(sh_i_ff);
         col_wdata = col_rd_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (row_we) begin
         row_mem[row_waddr] <= row_wdata;
      end
      if (perm_re) begin
         row_rd_a_ff <= row_mem[row_raddr_a];
         row_rd_b_ff <= row_mem[RIW'(sh_k_ff)];
      end
   end

   always_ff @(posedge clock) begin
      if (col_we) begin
         col_mem[col_waddr] <= col_wdata;
      end
      if (perm_re) begin
         col_rd_a_ff <= col_mem[col_raddr_a];
         col_rd_b_ff <= col_mem[CIW'(sh_k_ff)];
      end
   end

   // ------------------------------------------------------------------------
   // Load and pixel pipeline
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         p3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         p1_valid_ff  <= load_acc || pix_acc;
         p2_valid_ff  <= p1_valid_ff;
         p3_valid_ff  <= p2_valid_ff;
         rsp_valid_ff <= p3_valid_ff && p3_pixel_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_pixel_ff  <= pix_acc;
         p1_first_ff  <= req_data.first_pixel;
         p1_second_ff <= req_data.second_pixel;
         p1_addr_ff   <= sia_pkg::STORE_AW'(load_pos_ff);
         p1_start_ff  <= cur_start;
         p1_last_ff   <= cur_last;

         p2_pixel_ff  <= p1_pixel_ff;
         p2_first_ff  <= p1_first_ff;
         p2_second_ff <= p1_second_ff;
         p2_addr_ff   <= p1_addr_ff;
         p2_start_ff  <= p1_start_ff;
         p2_last_ff   <= p1_last_ff;
         p2_prod_ff   <= FRW'(FRW'(row_rd_a_ff) * FRW'(col_count_ff));
         p2_cp_ff     <= col_rd_a_ff;

         p3_pixel_ff  <= p2_pixel_ff;
         p3_first_ff  <= p2_first_ff;
         p3_start_ff  <= p2_start_ff;
         p3_last_ff   <= p2_last_ff;
      end
   end

   // Loads write and pixels read the image store in the same stage, so the
   // store sees every access in transfer order.
   assign store_addr = p2_pixel_ff ? sia_pkg::STORE_AW'(p2_prod_ff + FRW'(p2_cp_ff))
                                   : p2_addr_ff;

   always_ff @(posedge clock) begin
      if (adv && p2_valid_ff) begin
         if (p2_pixel_ff) begin
            store_rd_ff <= store_mem[store_addr];
         end else begin
            store_mem[store_addr] <= p2_second_ff;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Add, clip and count
   // ------------------------------------------------------------------------
   always_comb begin
      sum = {{(sia_pkg::CNT_W + 1 - sia_pkg::FIRST_W){1'b0}}, p3_first_ff} +
            {{(sia_pkg::CNT_W + 1 - sia_pkg::SECOND_W){store_rd_ff[sia_pkg::SECOND_W-1]}},
             store_rd_ff};
      sum_low  = sum[sia_pkg::CNT_W];
      sum_high = !sum_low && (sum[sia_pkg::CNT_W-1:sia_pkg::FIRST_W] != '0);

      low_base  = p3_start_ff ? '0 : low_clips_ff;
      high_base = p3_start_ff ? '0 : high_clips_ff;

      rsp_in.clipped_low  = sum_low;
      rsp_in.clipped_high = sum_high;
      rsp_in.frame_end    = p3_last_ff;
      if (sum_low) begin
         rsp_in.out_pixel = '0;
      end else if (sum_high) begin
         rsp_in.out_pixel = sia_pkg::PIXEL_MAX;
      end else begin
         rsp_in.out_pixel = sum[sia_pkg::FIRST_W-1:0];
      end
      rsp_in.low_clip_total  = (sum_low && low_base != sia_pkg::CNT_MAX) ?
                               low_base + 1'b1 : low_base;
      rsp_in.high_clip_total = (sum_high && high_base != sia_pkg::CNT_MAX) ?
                               high_base + 1'b1 : high_base;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_clips_ff  <= '0;
         high_clips_ff <= '0;
      end else if (adv && p3_valid_ff && p3_pixel_ff) begin
         low_clips_ff  <= rsp_in.low_clip_total;
         high_clips_ff <= rsp_in.high_clip_total;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the shuffled image add-and-clip block.
// Items stream through a bursty driver while the result side stalls on a
// changing pattern. A local model of the second image, the row and column
// permutations and the clip counters predicts every pixel result. The
// monitor checks each result transfer against the oldest prediction, field by
// field. Image sizes are changed only while the block is idle.
// ----------------------------------------------------------------------------
module tb;
   import sia_pkg::*;

   localparam int MAX_ROWS = 256;
   localparam int MAX_COLS = 256;
   localparam int DRAIN_CYCLES = 64;
   localparam int BODY_ITEMS = 140;
   localparam int PHASES = 10;
   localparam int unsigned CYCLE_LIMIT = 2000000;
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HALF, STALL_LONG} stall_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   sia_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   sia_rsp_type rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Items waiting to be driven, and pixel results predicted but not yet seen.
   sia_req_type image_items[$];
   sia_rsp_type predicted_pixels[$];

   // Model of the block.
   logic signed [SECOND_W-1:0] second_image [0:STORE_DEPTH-1];
   logic [7:0]  row_map [0:MAX_ROWS-1];
   logic [7:0]  col_map [0:MAX_COLS-1];
   int unsigned rows, cols, load_ptr, swap_idx, pix_r, pix_c;
   int unsigned low_clips_seen, high_clips_seen;

   // Sizes as the stimulus side last wrote them.
   int unsigned plan_rows = MAX_ROWS;
   int unsigned plan_cols = MAX_COLS;

   int unsigned mismatches = 0;
   int unsigned cycle_count = 0;
   logic        req_taken = 1'b0;
   int          burst_left = 1;
   int          gap_left = 0;
   int          stall_left = 0;
   stall_mode_type stall_mode = STALL_NONE;

   shuffled_image_add_clip #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic int unsigned clamp_size(input int unsigned v, input int unsigned top);
      if (v == 0) return 1;
      if (v > top) return top;
      return v;
   endfunction

   task automatic restart_streams();
      load_ptr = 0;
      swap_idx = 0;
      pix_r = 0;
      pix_c = 0;
   endtask

   task automatic check_field(input string name, input logic [CNT_W-1:0] want,
                              input logic [CNT_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   task automatic add_item(input logic [KIND_W-1:0] kind, input logic [31:0] first,
                           input logic [31:0] second, input logic [31:0] word);
      sia_req_type item;
      item.kind = kind;
      item.first_pixel = first[FIRST_W-1:0];
      item.second_pixel = second[SECOND_W-1:0];
      item.random_word = word[RAND_W-1:0];
      image_items.push_back(item);
   endtask

   task automatic set_size(input logic [CSR_IDX_W-1:0] index,
                           input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      forever begin
         @(posedge clock);
         if (csr_ready) break;
      end
      @(negedge clock);
      csr_valid <= 1'b0;
      if (index == CSR_ROW_COUNT)
         plan_rows = clamp_size(value, MAX_ROWS);
      else
         plan_cols = clamp_size(value, MAX_COLS);
   endtask

   // Waits until every item is in and every result is out, then lets a
   // trailing shuffle finish before the caller touches the size registers.
   task automatic settle();
      forever begin
         @(posedge clock);
         if (image_items.size() == 0 && !req_valid && predicted_pixels.size() == 0) break;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Sender: bursts of transfers separated by random gaps.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (gap_left > 0) begin
            gap_left = gap_left - 1;
            req_valid <= 1'b0;
         end else if (image_items.size() > 0) begin
            req_data <= image_items.pop_front();
            req_valid <= 1'b1;
            burst_left = burst_left - 1;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: the stall pattern changes after a run of random length.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_left == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 3));
            stall_left = $urandom_range(16, 200);
         end else begin
            stall_left = stall_left - 1;
         end
         case (stall_mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HALF:  rsp_stall <= $urandom_range(0, 1);
            default:     rsp_stall <= (stall_left % 8) < 5;
         endcase
      end
   end

   // Monitor: updates the model on every transfer and checks each result.
   always @(posedge clock) begin : monitor
      sia_rsp_type want;
      int sum;
      int unsigned addr, pick, pos, steps_total;
      logic [7:0] held;

      req_taken <= req_valid && !req_stall;
      if (reset) begin
         rows = MAX_ROWS;
         cols = MAX_COLS;
         for (int n = 0; n < MAX_ROWS; n++) row_map[n] = n;
         for (int n = 0; n < MAX_COLS; n++) col_map[n] = n;
         restart_streams();
         low_clips_seen = 0;
         high_clips_seen = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ROW_COUNT: begin
                  rows = clamp_size(csr_wdata, MAX_ROWS);
                  for (int n = 0; n < MAX_ROWS; n++) row_map[n] = n;
                  restart_streams();
               end
               CSR_COL_COUNT: begin
                  cols = clamp_size(csr_wdata, MAX_COLS);
                  for (int n = 0; n < MAX_COLS; n++) col_map[n] = n;
                  restart_streams();
               end
               default: ;
            endcase
         end

         if (req_valid && !req_stall) begin
            case (req_data.kind)
               KIND_LOAD: begin
                  second_image[load_ptr % STORE_DEPTH] = req_data.second_pixel;
                  load_ptr++;
                  if (load_ptr >= rows * cols) load_ptr = 0;
               end
               KIND_SHUFFLE: begin
                  // One Fisher-Yates step: all row steps first, then the columns.
                  steps_total = (rows - 1) + (cols - 1);
                  if (steps_total != 0) begin
                     if (swap_idx >= steps_total) swap_idx = 0;
                     if (swap_idx < rows - 1) begin
                        pick = req_data.random_word % (rows - swap_idx) + swap_idx;
                        held = row_map[pick];
                        row_map[pick] = row_map[swap_idx];
                        row_map[swap_idx] = held;
                     end else begin
                        pos = swap_idx - (rows - 1);
                        pick = req_data.random_word % (cols - pos) + pos;
                        held = col_map[pick];
                        col_map[pick] = col_map[pos];
                        col_map[pos] = held;
                     end
                     swap_idx++;
                     if (swap_idx >= steps_total) swap_idx = 0;
                  end
               end
               KIND_PIXEL: begin
                  if (pix_r >= rows || pix_c >= cols) begin
                     pix_r = 0;
                     pix_c = 0;
                  end
                  if (pix_r == 0 && pix_c == 0) begin
                     low_clips_seen = 0;
                     high_clips_seen = 0;
                  end
                  addr = ((row_map[pix_r] % rows) * cols + (col_map[pix_c] % cols))
                         % STORE_DEPTH;
                  sum = int'(req_data.first_pixel) + int'(second_image[addr]);
                  want = '0;
                  if (sum < 0) begin
                     want.clipped_low = 1'b1;
                     if (low_clips_seen < CNT_MAX) low_clips_seen++;
                  end else if (sum > int'(PIXEL_MAX)) begin
                     want.out_pixel = PIXEL_MAX;
                     want.clipped_high = 1'b1;
                     if (high_clips_seen < CNT_MAX) high_clips_seen++;
                  end else begin
                     want.out_pixel = sum[FIRST_W-1:0];
                  end
                  want.low_clip_total = low_clips_seen[CNT_W-1:0];
                  want.high_clip_total = high_clips_seen[CNT_W-1:0];
                  want.frame_end = (pix_r == rows - 1) && (pix_c == cols - 1);
                  pix_c++;
                  if (pix_c >= cols) begin
                     pix_c = 0;
                     pix_r++;
                     if (pix_r >= rows) pix_r = 0;
                  end
                  predicted_pixels.push_back(want);
               end
               default: ;
            endcase
         end

         if (rsp_valid && !rsp_stall) begin
            if (predicted_pixels.size() == 0) begin
               $display("%0t: result with nothing expected, got %p", $time, rsp_data);
               mismatches++;
            end else begin
               want = predicted_pixels.pop_front();
               check_field("out_pixel", want.out_pixel, rsp_data.out_pixel);
               check_field("clipped_low", want.clipped_low, rsp_data.clipped_low);
               check_field("clipped_high", want.clipped_high, rsp_data.clipped_high);
               check_field("low_clip_total", want.low_clip_total, rsp_data.low_clip_total);
               check_field("high_clip_total", want.high_clip_total,
                           rsp_data.high_clip_total);
               check_field("frame_end", want.frame_end, rsp_data.frame_end);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("shuffled_image_add_clip: mismatch");
         $finish;
      end
   end

   initial begin
      logic [CSR_DATA_W-1:0] phase_rows [5];
      logic [CSR_DATA_W-1:0] phase_cols [5];
      logic [CSR_DATA_W-1:0] want_rows, want_cols;
      int unsigned frame, written_span, body_count, run_len, steps_total;
      int weight;

      // Degenerate, tallest, widest, and out-of-range sizes come first.
      phase_rows = '{9'd1, 9'd256, 9'd1, 9'd0, 9'd300};
      phase_cols = '{9'd1, 9'd1, 9'd256, 9'd511, 9'd0};

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed frame of 2 x 3: clip at both ends, exact bounds, frame end,
      // extreme random words, an ignored item, then the shuffled frame.
      set_size(CSR_ROW_COUNT, 9'd2);
      set_size(CSR_COL_COUNT, 9'd3);
      add_item(KIND_LOAD, $urandom, 32'hFFFF_8000, $urandom);
      add_item(KIND_LOAD, $urandom, 32'h0000_7FFF, $urandom);
      add_item(KIND_LOAD, $urandom, 32'h0, $urandom);
      add_item(KIND_LOAD, $urandom, 32'hFFFF_FFFF, $urandom);
      add_item(KIND_LOAD, $urandom, 32'd100, $urandom);
      add_item(KIND_LOAD, $urandom, -32'sd200, $urandom);
      add_item(KIND_PIXEL, 32'd0, $urandom, $urandom);
      add_item(KIND_PIXEL, 32'd255, $urandom, $urandom);
      add_item(KIND_PIXEL, 32'd255, $urandom, $urandom);
      add_item(KIND_PIXEL, 32'd0, $urandom, $urandom);
      add_item(KIND_PIXEL, 32'd255, $urandom, $urandom);
      add_item(KIND_PIXEL, 32'd200, $urandom, $urandom);
      add_item(KIND_SHUFFLE, $urandom, $urandom, 32'd0);
      add_item(KIND_SHUFFLE, $urandom, $urandom, 32'h7FFF_FFFF);
      add_item(KIND_SHUFFLE, $urandom, $urandom, 32'd5);
      add_item(KIND_UNUSED, $urandom, $urandom, $urandom);
      repeat (6) add_item(KIND_PIXEL, $urandom, $urandom, $urandom);
      written_span = 6;
      settle();

      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase < 5) begin
            want_rows = phase_rows[phase];
            want_cols = phase_cols[phase];
         end else begin
            want_rows = $urandom_range(2, 16);
            want_cols = $urandom_range(1, 16);
         end
         if ($urandom_range(0, 1)) begin
            set_size(CSR_ROW_COUNT, want_rows);
            set_size(CSR_COL_COUNT, want_cols);
         end else begin
            set_size(CSR_COL_COUNT, want_cols);
            set_size(CSR_ROW_COUNT, want_rows);
         end
         // Rewriting a size with the same value still restarts the streams.
         if ($urandom_range(0, 2) == 0) set_size(CSR_ROW_COUNT, want_rows);

         frame = plan_rows * plan_cols;
         // Every store entry the frame can address must be written first.
         if (frame > written_span) begin
            for (int n = 0; n < frame; n++) add_item(KIND_LOAD, $urandom, $urandom, $urandom);
            written_span = frame;
         end

         body_count = 0;
         while (body_count < BODY_ITEMS) begin
            weight = $urandom_range(0, 9);
            if (weight < 5) begin
               run_len = $urandom_range(1, (frame < 40) ? frame : 40);
               repeat (run_len) add_item(KIND_PIXEL, $urandom, $urandom, $urandom);
            end else if (weight < 7) begin
               steps_total = plan_rows + plan_cols - 2;
               run_len = $urandom_range(1, (steps_total < 2) ? 1 :
                                           (steps_total > 12) ? 12 : steps_total);
               repeat (run_len) add_item(KIND_SHUFFLE, $urandom, $urandom, $urandom);
            end else if (weight < 9) begin
               run_len = $urandom_range(1, (frame < 16) ? frame : 16);
               repeat (run_len) begin
                  if ($urandom_range(0, 1))
                     add_item(KIND_LOAD, $urandom, $urandom, $urandom);
                  else
                     add_item(KIND_LOAD, $urandom, $urandom_range(0, 767) - 512, $urandom);
               end
            end else begin
               add_item(KIND_UNUSED, $urandom, $urandom, $urandom);
               run_len = 0;
            end
            body_count += run_len;
         end
         settle();
      end

      if (mismatches == 0)
         $display("shuffled_image_add_clip: match");
      else
         $display("shuffled_image_add_clip: mismatch");
      $finish;
   end

endmodule
